/* sv/cwl_pkg.sv */
// ----------------------------------------------------------------------------
// cwl_pkg
// shared codes and transfer types of the card whitelist table
// ----------------------------------------------------------------------------
package cwl_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned LIMIT_W  = 5;
  localparam int unsigned COUNT_W  = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_GRANTED = 3'd0,
    ST_DENIED  = 3'd1,
    ST_ADDED   = 3'd2,
    ST_PRESENT = 3'd3,
    ST_FULL    = 3'd4,
    ST_DELETED = 3'd5,
    ST_ABSENT  = 3'd6
  } status_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [ID_W-1:0] card_id;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] card_count;
  } res_t;

endpackage

/* sv/cwl_core.sv */
// ----------------------------------------------------------------------------
// cwl_core
// table memory, entry count and the scan / compaction sequencer
// ----------------------------------------------------------------------------
module cwl_core
  import cwl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] max_cards,
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_SH_RD = 6'b001000,
    S_SH_WR = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [ID_W-1:0] mem [TABLE_ENTRIES];
  logic [ID_W-1:0] rdata;

  logic            rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic            we;
  logic [IDX_W-1:0] waddr;
  logic [ID_W-1:0] wdata;

  logic [1:0]       mode_r;
  logic [ID_W-1:0]  id_r;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  status_t          status_r, status_next;

  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CMP_W-1:0] count_ext;
  logic             full;

  assign idx_inc   = idx + CNT_W'(1);
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign count_ext = CMP_W'(count);
  assign full      = (count_ext >= CMP_W'(max_cards)) ||
                     (count >= CNT_W'(TABLE_ENTRIES));

  always_comb begin
    state_next  = state;
    idx_next    = idx;
    count_next  = count;
    status_next = status_r;
    rd_en       = 1'b0;
    rd_addr     = idx[IDX_W-1:0];
    we          = 1'b0;
    waddr       = idx[IDX_W-1:0];
    wdata       = rdata;
    req_ready   = 1'b0;
    res_valid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          idx_next   = '0;
          state_next = S_RD;
        end
      end
      S_RD: begin
        if (idx < count) begin
          rd_en      = 1'b1;
          state_next = S_CMP;
        end else begin
          // no match anywhere in the valid entries
          state_next = S_RESP;
          if (mode_r == MODE_ADD) begin
            if (full) begin
              status_next = ST_FULL;
            end else begin
              we          = 1'b1;
              waddr       = count[IDX_W-1:0];
              wdata       = id_r;
              count_next  = count_inc;
              status_next = ST_ADDED;
            end
          end else if (mode_r == MODE_DELETE) begin
            status_next = ST_ABSENT;
          end else begin
            status_next = ST_DENIED;
          end
        end
      end
      S_CMP: begin
        if (rdata == id_r) begin
          if (mode_r == MODE_ADD) begin
            status_next = ST_PRESENT;
            state_next  = S_RESP;
          end else if (mode_r == MODE_DELETE) begin
            state_next = S_SH_RD;
          end else begin
            status_next = ST_GRANTED;
            state_next  = S_RESP;
          end
        end else begin
          idx_next   = idx_inc;
          state_next = S_RD;
        end
      end
      S_SH_RD: begin
        if (idx_inc < count) begin
          rd_en      = 1'b1;
          rd_addr    = idx_inc[IDX_W-1:0];
          state_next = S_SH_WR;
        end else begin
          count_next  = count_dec;
          status_next = ST_DELETED;
          state_next  = S_RESP;
        end
      end
      S_SH_WR: begin
        // move the later entry down one place
        we         = 1'b1;
        idx_next   = idx_inc;
        state_next = S_SH_RD;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    idx      <= idx_next;
    status_r <= status_next;
    if (req_valid && req_ready) begin
      mode_r <= req.mode;
      id_r   <= req.card_id;
    end
  end

  assign res.status     = status_r;
  assign res.card_count = count_ext[COUNT_W-1:0];

  // count never goes past the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  // count only moves when an add or delete finishes
  a_count_move: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (state == S_RESP &&
      (mode_r == MODE_ADD || mode_r == MODE_DELETE)))
    else $error("entry count changed outside an add or delete");

  // a taken request starts the scan
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_RD && idx == '0))
    else $error("scan did not start after request transfer");

  // no table write while idle or answering
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_RD || state == S_SH_WR))
    else $error("table written outside add or compaction");

endmodule

/* sv/card_id_whitelist_table_top.sv */
// ----------------------------------------------------------------------------
// card_id_whitelist_table_top
// packed whitelist of 32-bit card ids: lookup, add and delete with compaction
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  cfg     | in        | cfg_valid, cfg_ready, cfg_data (max_cards)
//  in      | in        | in_valid, in_ready, mode, card_id
//  out     | out       | out_valid, out_ready, status, card_count
//
//  an item's time is set by n = stored entries and the
//  single-port table memory: one read per entry during the scan, then one
//  read and one write per later entry when a delete closes the gap
//  one item in flight; the next is taken while the last result waits
//  reset empties the table (count zero) and sets max_cards to 16
//  cfg writes are taken every cycle
// ----------------------------------------------------------------------------
module card_id_whitelist_table_top
  import cwl_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [ID_W-1:0]    card_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [COUNT_W-1:0] card_count
);

  logic [LIMIT_W-1:0] max_cards;
  req_t               req;
  res_t               core_res;
  res_t               out_res;
  logic               core_res_valid;
  logic               core_res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_cards <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_cards <= cfg_data;
    end
  end

  assign req.mode    = mode;
  assign req.card_id = card_id;

  cwl_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .max_cards (max_cards),
    .req_valid (in_valid),
    .req_ready (in_ready),
    .req       (req),
    .res_valid (core_res_valid),
    .res_ready (core_res_ready),
    .res       (core_res)
  );

  // output register
  assign core_res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_res_ready) begin
      out_valid <= core_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_res_valid && core_res_ready) begin
      out_res <= core_res;
    end
  end

  assign status     = out_res.status;
  assign card_count = out_res.card_count;

endmodule

/* tb/card_id_whitelist_table_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_id_whitelist_table_top_tb
// self-checking bench for the card whitelist table: a short table of directed
// lookups, adds and deletes, mostly with hand-written verdicts, then random
// transfers mostly from a small pool of card ids under a series of max_cards
// settings, scored against a model of the packed table kept in the bench
// ----------------------------------------------------------------------------
module card_id_whitelist_table_top_tb;
  import cwl_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int POOL_SIZE = 20;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 150;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic               is_limit;
    logic [1:0]         op;
    logic [ID_W-1:0]    id;
    logic               typed;
    status_t            st;
    logic [COUNT_W-1:0] cnt;
  } drill_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_LOOKUP;
  logic [ID_W-1:0]    card_id = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [COUNT_W-1:0] card_count;

  // verdict typed into the directed table, carried alongside the payload
  logic               row_typed = 1'b0;
  status_t            row_status = ST_DENIED;
  logic [COUNT_W-1:0] row_count = '0;

  logic               hold_req = 1'b0;
  logic               hold_done = 1'b0;

  logic [ID_W-1:0]    white_ids [TABLE_ENTRIES];
  int                 white_count;
  logic [LIMIT_W-1:0] limit_reg;
  res_t               verdict_q [$];
  drill_row_t         drill [$];
  int                 status_tally [7];
  int                 items_sent = 0;
  int                 verdicts_seen = 0;
  int                 limit_writes = 0;
  int                 peak_count = 0;
  int                 faults = 0;
  int                 cycles = 0;
  int                 send_idle = 29;
  int                 recv_idle = 51;

  always #10 clk = ~clk;

  card_id_whitelist_table_top #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .card_id   (card_id),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .card_count(card_count)
  );

  function automatic res_t whitelist_verdict(input logic [1:0] op, input logic [ID_W-1:0] id);
    int   hit;
    int   cap;
    res_t r;
    hit = -1;
    for (int k = 0; k < white_count; k++) begin
      if (hit < 0 && white_ids[k] == id) hit = k;
    end
    cap = (limit_reg < TABLE_ENTRIES) ? int'(limit_reg) : TABLE_ENTRIES;
    case (op)
      MODE_ADD: begin
        if (hit >= 0) begin
          r.status = ST_PRESENT;
        end else if (white_count >= cap) begin
          r.status = ST_FULL;
        end else begin
          white_ids[white_count] = id;
          white_count++;
          r.status = ST_ADDED;
        end
      end
      MODE_DELETE: begin
        if (hit < 0) begin
          r.status = ST_ABSENT;
        end else begin
          for (int k = hit; k < white_count - 1; k++) white_ids[k] = white_ids[k + 1];
          white_count--;
          r.status = ST_DELETED;
        end
      end
      default: begin
        r.status = (hit >= 0) ? ST_GRANTED : ST_DENIED;
      end
    endcase
    r.card_count = COUNT_W'(white_count);
    status_tally[r.status]++;
    if (white_count > peak_count) peak_count = white_count;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    res_t fresh;
    res_t want;
    if (rst) begin
      white_count = 0;
      limit_reg = LIMIT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) limit_reg = cfg_data;
      if (in_valid && in_ready) begin
        fresh = whitelist_verdict(mode, card_id);
        if (row_typed) begin
          fresh.status = row_status;
          fresh.card_count = row_count;
        end
        verdict_q.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
          $error("unexpected result transfer: status %0d card_count %0d", status, card_count);
          faults++;
        end else begin
          want = verdict_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            faults++;
          end
          if (card_count !== want.card_count) begin
            $error("card_count: expected %0d, actual %0d", want.card_count, card_count);
            faults++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("card_id_whitelist_table_top test failed");
      $finish;
    end
  end

  initial begin : receiver
    int held;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [ID_W-1:0] id, input logic typed,
                           input status_t st, input logic [COUNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    card_id    <= id;
    row_typed  <= typed;
    row_status <= st;
    row_count  <= cnt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // max_cards only changes with nothing in flight
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    in_valid <= 1'b0;
    while (verdicts_seen < items_sent) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  task automatic row_item(input logic [1:0] op, input logic [ID_W-1:0] id, input status_t st,
                          input logic [COUNT_W-1:0] cnt);
    drill.push_back('{1'b0, op, id, 1'b1, st, cnt});
  endtask

  task automatic row_free(input logic [1:0] op, input logic [ID_W-1:0] id);
    drill.push_back('{1'b0, op, id, 1'b0, ST_DENIED, '0});
  endtask

  task automatic row_limit(input logic [LIMIT_W-1:0] value);
    drill.push_back('{1'b1, MODE_LOOKUP, ID_W'(value), 1'b0, ST_DENIED, '0});
  endtask

  initial begin : stimulus
    logic [ID_W-1:0]    pool [POOL_SIZE];
    logic [LIMIT_W-1:0] limit_plan [PHASES];
    logic [1:0]         op;
    logic [ID_W-1:0]    id;
    int                 pick;
    int                 phase;
    int                 k;
    int                 idx;

    limit_plan = '{5'd31, 5'd16, 5'd1, 5'd0, 5'd7, 5'd16, 5'd3, 5'd20, 5'd12, 5'd16};
    pool[0] = '0;
    pool[1] = '1;
    for (k = 2; k < POOL_SIZE; k++) pool[k] = $urandom;

    // empty table, duplicates, unused mode, partial byte matches
    row_item(MODE_LOOKUP, 32'h0000_0000, ST_DENIED, 5'd0);
    row_item(MODE_DELETE, 32'hFFFF_FFFF, ST_ABSENT, 5'd0);
    row_item(MODE_ADD, 32'h0000_0000, ST_ADDED, 5'd1);
    row_item(MODE_ADD, 32'hFFFF_FFFF, ST_ADDED, 5'd2);
    row_item(MODE_ADD, 32'hFFFF_FFFF, ST_PRESENT, 5'd2);
    row_item(MODE_LOOKUP, 32'hFFFF_FFFF, ST_GRANTED, 5'd2);
    row_free(MODE_SPARE, 32'h0000_0000);
    row_item(MODE_LOOKUP, 32'h0000_00FF, ST_DENIED, 5'd2);
    row_item(MODE_LOOKUP, 32'hFFFF_7FFF, ST_DENIED, 5'd2);
    row_item(MODE_ADD, 32'h1234_5678, ST_ADDED, 5'd3);
    // removing the head entry closes the gap
    row_item(MODE_DELETE, 32'h0000_0000, ST_DELETED, 5'd2);
    row_free(MODE_LOOKUP, 32'hFFFF_FFFF);
    row_free(MODE_LOOKUP, 32'h1234_5678);
    row_free(MODE_LOOKUP, 32'h0000_0000);
    row_limit(5'd2);
    row_item(MODE_ADD, 32'hA5A5_A5A5, ST_FULL, 5'd2);
    row_item(MODE_ADD, 32'h1234_5678, ST_PRESENT, 5'd2);
    // limit now below the count
    row_limit(5'd1);
    row_item(MODE_ADD, 32'h5A5A_5A5A, ST_FULL, 5'd2);
    row_item(MODE_DELETE, 32'hFFFF_FFFF, ST_DELETED, 5'd1);
    row_item(MODE_ADD, 32'h5A5A_5A5A, ST_FULL, 5'd1);
    row_item(MODE_DELETE, 32'h1234_5678, ST_DELETED, 5'd0);
    row_item(MODE_ADD, 32'h5A5A_5A5A, ST_ADDED, 5'd1);
    row_limit(5'd0);
    row_item(MODE_ADD, 32'h00C0_FFEE, ST_FULL, 5'd1);
    row_item(MODE_DELETE, 32'h5A5A_5A5A, ST_DELETED, 5'd0);
    row_item(MODE_ADD, 32'h5A5A_5A5A, ST_FULL, 5'd0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (drill[r]) begin
      if (drill[r].is_limit) begin
        set_limit(drill[r].id[LIMIT_W-1:0]);
      end else begin
        send_item(drill[r].op, drill[r].id, drill[r].typed, drill[r].st, drill[r].cnt);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      set_limit(limit_plan[phase]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        idx = phase * PHASE_ITEMS + k;
        if (idx == 10) hold_req <= 1'b1;
        if (idx == PHASES * PHASE_ITEMS / 3) begin
          send_idle = 51;
          recv_idle = 29;
        end
        if (idx == 2 * PHASES * PHASE_ITEMS / 3) begin
          send_idle = 0;
          recv_idle = 0;
        end
        pick = $urandom_range(99);
        if (pick < 30) op = MODE_LOOKUP;
        else if (pick < 75) op = MODE_ADD;
        else if (pick < 96) op = MODE_DELETE;
        else op = MODE_SPARE;
        pick = $urandom_range(99);
        if (pick < 80) id = pool[$urandom_range(POOL_SIZE - 1)];
        else if (pick < 92) id = $urandom;
        else id = pool[$urandom_range(POOL_SIZE - 1)] ^ (32'h0000_0001 << $urandom_range(31));
        send_item(op, id, 1'b0, ST_DENIED, '0);
      end
    end

    in_valid <= 1'b0;
    while (verdicts_seen < items_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      faults++;
    end

    $display("run: %0d transfers in, %0d out, %0d max_cards writes, table peaked at %0d entries",
             items_sent, verdicts_seen, limit_writes, peak_count);
    $display("verdicts: granted %0d denied %0d added %0d present %0d full %0d deleted %0d absent %0d",
             status_tally[ST_GRANTED], status_tally[ST_DENIED], status_tally[ST_ADDED],
             status_tally[ST_PRESENT], status_tally[ST_FULL], status_tally[ST_DELETED],
             status_tally[ST_ABSENT]);
    if (faults == 0) begin
      $display("card_id_whitelist_table_top test passed");
    end else begin
      $display("card_id_whitelist_table_top test failed");
    end
    $finish;
  end

endmodule
